// ===== design/bdpc_pkg.sv =====
`default_nettype none

package bdpc_pkg;

    localparam int unsigned INDEX_W    = 30;
    localparam int unsigned QUOT_W     = 30;
    localparam int unsigned DIGIT_W    = 6;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned CHAR_SLOTS = 5;
    localparam int unsigned HASH_W     = 32;
    localparam int unsigned TALLY_W    = 16;

    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 88;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TARGET_HASH = 1'b0;

    localparam logic [HASH_W-1:0]  HASH_SEED    = 32'd5381;
    localparam logic [HASH_W-1:0]  TARGET_RESET = 32'h0BDC_96A4;
    localparam logic [TALLY_W-1:0] TALLY_MAX    = 16'hFFFF;

    // floor(n / 62) == floor((n >> 1) / 31); reciprocal of 31 is exact over 29 bits
    localparam int unsigned       RECIP_W     = 30;
    localparam int unsigned       RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP31    = 30'd554189329;
    localparam int unsigned       PROD_W      = (INDEX_W - 1) + RECIP_W;

    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [DIGIT_W-1:0] UPPER_LIMIT   = 6'd36;
    localparam logic [CHAR_W-1:0]  DIGIT_OFFSET  = 7'd48;
    localparam logic [CHAR_W-1:0]  UPPER_OFFSET  = 7'd55;
    localparam logic [CHAR_W-1:0]  LOWER_OFFSET  = 7'd61;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t [CHAR_SLOTS-1:0] char_row_t;

    typedef struct packed {
        logic [QUOT_W-1:0]  quot;
        logic [DIGIT_W-1:0] digit;
    } divmod_t;

    function automatic divmod_t divmod62(input logic [INDEX_W-1:0] n);
        logic [INDEX_W-2:0] half;
        logic [PROD_W-1:0]  prod;
        logic [QUOT_W-1:0]  q;
        logic [INDEX_W-1:0] times62;
        divmod_t            res;
        half    = n[INDEX_W-1:1];
        prod    = PROD_W'(half) * PROD_W'(RECIP31);
        q       = QUOT_W'(prod[PROD_W-1:RECIP_SHIFT]);
        times62 = {q[QUOT_W-7:0], 6'b0} - {q[QUOT_W-2:0], 1'b0};
        res.quot  = q;
        res.digit = DIGIT_W'(n - times62);
        return res;
    endfunction

    function automatic char_t digit_to_ascii(input logic [DIGIT_W-1:0] d);
        char_t c;
        if (d < DECIMAL_LIMIT) begin
            c = DIGIT_OFFSET + CHAR_W'(d);
        end else if (d < UPPER_LIMIT) begin
            c = UPPER_OFFSET + CHAR_W'(d);
        end else begin
            c = LOWER_OFFSET + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/bdpc_front.sv =====
`default_nettype none

module bdpc_front
    import bdpc_pkg::*;
#(
    parameter int unsigned STRING_LENGTH = 5
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [INDEX_W-1:0] s_index,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output char_row_t               q_chars
);

    logic [STRING_LENGTH:0]   v_reg;
    logic [STRING_LENGTH+1:0] rdy;
    logic [QUOT_W-1:0]        quot_reg  [0:STRING_LENGTH-1];
    char_row_t                chars_reg [1:STRING_LENGTH];

    assign rdy[STRING_LENGTH+1] = q_ready;
    assign s_ready = rdy[0];
    assign q_valid = v_reg[STRING_LENGTH];
    assign q_chars = chars_reg[STRING_LENGTH];

    genvar s;
    generate
        for (s = 0; s <= STRING_LENGTH; s++) begin : g_rdy
            assign rdy[s] = !v_reg[s] || rdy[s+1];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            v_reg[0] <= s_valid;
        end
        if (rdy[0] && s_valid) begin
            quot_reg[0] <= QUOT_W'(s_index);
        end
    end

    // stage s peels the next least significant digit into slot STRING_LENGTH-s
    generate
        for (s = 1; s <= STRING_LENGTH; s++) begin : g_digit
            divmod_t   dm;
            char_row_t chars_src;
            char_row_t chars_next;

            if (s == 1) begin : g_first
                assign chars_src = '0;
            end else begin : g_rest
                assign chars_src = chars_reg[s-1];
            end

            always_comb begin
                dm = divmod62(INDEX_W'(quot_reg[s-1]));
                chars_next = chars_src;
                chars_next[STRING_LENGTH-s] = digit_to_ascii(dm.digit);
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[s] <= 1'b0;
                end else if (rdy[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
                if (rdy[s] && v_reg[s-1]) begin
                    chars_reg[s] <= chars_next;
                end
            end

            if (s < STRING_LENGTH) begin : g_quot
                always_ff @(posedge aclk) begin
                    if (rdy[s] && v_reg[s-1]) begin
                        quot_reg[s] <= dm.quot;
                    end
                end
            end
        end
    endgenerate

endmodule

`default_nettype wire

// ===== design/bdpc_queue.sv =====
`default_nettype none

module bdpc_queue
    import bdpc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire char_row_t in_chars,
    output logic           out_valid,
    input  wire logic      out_ready,
    output char_row_t      out_chars
);

    char_row_t         mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_chars = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_chars;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue occupancy did not follow a lone push");

endmodule

`default_nettype wire

// ===== design/bdpc_back.sv =====
`default_nettype none

module bdpc_back
    import bdpc_pkg::*;
#(
    parameter int unsigned STRING_LENGTH = 5
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire char_row_t         q_chars,
    input  wire logic [HASH_W-1:0] target_hash,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_match,
    output logic [HASH_W-1:0]      m_hash,
    output char_row_t              m_chars,
    output logic [TALLY_W-1:0]     m_tally
);

    logic [STRING_LENGTH:1]   hv_reg;
    logic [STRING_LENGTH+1:1] rdy;
    logic [HASH_W-1:0]        hash_reg  [1:STRING_LENGTH];
    char_row_t                chars_reg [1:STRING_LENGTH];

    logic               out_valid_reg;
    logic               out_match_reg;
    logic [HASH_W-1:0]  out_hash_reg;
    char_row_t          out_chars_reg;
    logic [TALLY_W-1:0] out_tally_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [TALLY_W-1:0] tally_next;
    logic               hit_next;
    logic               take_out;

    assign rdy[STRING_LENGTH+1] = !out_valid_reg || m_ready;
    assign q_ready = rdy[1];

    genvar b;
    generate
        for (b = 1; b <= STRING_LENGTH; b++) begin : g_hash
            logic              src_valid;
            logic [HASH_W-1:0] src_hash;
            char_row_t         src_chars;
            logic [HASH_W-1:0] hash_next;

            assign rdy[b] = !hv_reg[b] || rdy[b+1];

            if (b == 1) begin : g_first
                assign src_valid = q_valid;
                assign src_hash  = HASH_SEED;
                assign src_chars = q_chars;
            end else begin : g_rest
                assign src_valid = hv_reg[b-1];
                assign src_hash  = hash_reg[b-1];
                assign src_chars = chars_reg[b-1];
            end

            // hash * 33 + c, wrapping at 32 bits
            assign hash_next = {src_hash[HASH_W-6:0], 5'b0} + src_hash
                             + HASH_W'(src_chars[b-1]);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    hv_reg[b] <= 1'b0;
                end else if (rdy[b]) begin
                    hv_reg[b] <= src_valid;
                end
                if (rdy[b] && src_valid) begin
                    hash_reg[b]  <= hash_next;
                    chars_reg[b] <= src_chars;
                end
            end
        end
    endgenerate

    assign take_out = hv_reg[STRING_LENGTH] && rdy[STRING_LENGTH+1];
    assign hit_next = (hash_reg[STRING_LENGTH] == target_hash);

    always_comb begin
        tally_next = tally_reg;
        if (take_out && hit_next && tally_reg != TALLY_MAX) begin
            tally_next = tally_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            tally_reg     <= '0;
        end else begin
            if (rdy[STRING_LENGTH+1]) begin
                out_valid_reg <= hv_reg[STRING_LENGTH];
            end
            tally_reg <= tally_next;
        end
        if (take_out) begin
            out_match_reg <= hit_next;
            out_hash_reg  <= hash_reg[STRING_LENGTH];
            out_chars_reg <= chars_reg[STRING_LENGTH];
            out_tally_reg <= tally_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_match = out_match_reg;
    assign m_hash  = out_hash_reg;
    assign m_chars = out_chars_reg;
    assign m_tally = out_tally_reg;

    a_tally_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            (tally_reg == $past(tally_reg) || tally_reg == $past(tally_reg) + 1'b1))
        else $error("match tally moved by more than one");

    a_tally_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !(take_out && hit_next) |=> $stable(tally_reg))
        else $error("match tally changed without a matching beat");

    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_match_reg |-> out_tally_reg != '0)
        else $error("matching beat carries a zero tally");

endmodule

`default_nettype wire

// ===== design/base62_djb2_preimage_check_top.sv =====
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata : candidate_index
// m_axis    out  m_tvalid/m_tready  m_tdata : hash, five chars, match count
//                                   m_tuser : is_match
// apb       in   psel/penable       target_hash at byte address 0
//
// One beat accepted per cycle while m_tready does not stall the output. A beat passes
// through the input register, one divide-by-62 stage per digit in the front, the queue
// and one shift-add hash stage per character in the back, then the output register.
// Synchronous active-low reset empties all stages and the queue, clears the tally
// and loads the target with its default. A stalled m_tready fills the output
// register, the hash stages, the two-entry queue, the digit stages and the input
// register before s_tready drops.

module base62_djb2_preimage_check_top
    import bdpc_pkg::*;
#(
    parameter int unsigned STRING_LENGTH = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [29:0] candidate_index
    input  wire logic [S_TDATA_W-1:0]  s_tdata,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] hash_value, [38:32] char_first, [45:39] char_second,
    // [52:46] char_third, [59:53] char_fourth, [66:60] char_fifth,
    // [82:67] matches_so_far
    output logic [M_TDATA_W-1:0]       m_tdata,
    // [0] is_match
    output logic                       m_tuser,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [HASH_W-1:0]    target_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic                 q_in_valid;
    logic                 q_in_ready;
    char_row_t            q_in_chars;
    logic                 q_out_valid;
    logic                 q_out_ready;
    char_row_t            q_out_chars;

    logic                 res_match;
    logic [HASH_W-1:0]    res_hash;
    char_row_t            res_chars;
    logic [TALLY_W-1:0]   res_tally;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready && (reg_idx == REG_TARGET_HASH);
    assign prdata    = (reg_idx == REG_TARGET_HASH) ? APB_DATA_W'(target_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
        end else if (cfg_write) begin
            target_reg <= HASH_W'(pwdata);
        end
    end

    bdpc_front #(
        .STRING_LENGTH (STRING_LENGTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_index (s_tdata[INDEX_W-1:0]),
        .q_valid (q_in_valid),
        .q_ready (q_in_ready),
        .q_chars (q_in_chars)
    );

    bdpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_chars  (q_in_chars),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_chars (q_out_chars)
    );

    bdpc_back #(
        .STRING_LENGTH (STRING_LENGTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_out_valid),
        .q_ready     (q_out_ready),
        .q_chars     (q_out_chars),
        .target_hash (target_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_match     (res_match),
        .m_hash      (res_hash),
        .m_chars     (res_chars),
        .m_tally     (res_tally)
    );

    assign m_tuser = res_match;
    assign m_tdata = {5'b0, res_tally, res_chars[4], res_chars[3], res_chars[2],
                      res_chars[1], res_chars[0], res_hash};

endmodule

`default_nettype wire
